>>> rtl/bomd_pkg.sv
package bomd_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int MAX_RES     = 4;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef enum logic [2:0] {
        ENC_UTF8    = 3'd0,
        ENC_UTF32BE = 3'd1,
        ENC_UTF32LE = 3'd2,
        ENC_UTF16BE = 3'd3,
        ENC_UTF16LE = 3'd4
    } enc_t;

    localparam logic [7:0] BYTE_00 = 8'h00;
    localparam logic [7:0] BYTE_EF = 8'hEF;
    localparam logic [7:0] BYTE_BB = 8'hBB;
    localparam logic [7:0] BYTE_BF = 8'hBF;
    localparam logic [7:0] BYTE_FE = 8'hFE;
    localparam logic [7:0] BYTE_FF = 8'hFF;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] offset;
        enc_t        enc;
        logic        incomplete;
        logic        run_last;
        logic        stream_done;
    } sym_t;

    // Results caused by one accepted byte, in order, count entries valid.
    typedef struct packed {
        logic [2:0]              count;
        sym_t [MAX_RES-1:0]      sym;
    } batch_t;

    // Length of a UTF-8 symbol from the leading ones of its lead byte.
    function automatic logic [2:0] utf8_length(input logic [7:0] b);
        logic [2:0] len;
        begin
            if (b[7:5] == 3'b110)
            begin
                len = 3'd2;
            end
            else if (b[7:4] == 4'b1110)
            begin
                len = 3'd3;
            end
            else if (b[7:4] == 4'b1111)
            begin
                len = 3'd4;
            end
            else
            begin
                len = 3'd1;
            end
            return len;
        end
    endfunction

endpackage

>>> rtl/bom_detect_symbol_reader.sv
// Channel | Direction | tdata                                   | tuser / tlast
// s_axis  | in        | [7:0] data_byte                         | tlast: end_of_input
// m_axis  | out       | [31:0] symbol_value, [63:32] symbol_offset | tuser [2:0]
//         |           |                                         | encoding_kind, [3] incomplete,
//         |           |                                         | [4] run_last; tlast: stream_done
//
// One byte is taken per cycle; each byte's results are computed in the cycle it is
// accepted and written into an eight-entry result queue, read out one per cycle.
// A head flush writes up to four results at once; s_tready drops while fewer than
// four queue entries are free, so the byte rate is bounded by m_tready.
// Reset (rst_n low, asynchronous) empties the queue and starts a new document.
module bom_detect_symbol_reader
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] symbol_value, [63:32] symbol_offset
    output logic [4:0]  m_tuser,   // [2:0] encoding_kind, [3] incomplete, [4] run_last
    output logic        m_tlast
);

    logic              accept;
    bomd_pkg::batch_t  batch;
    bomd_pkg::sym_t    out_sym;

    assign accept = s_tvalid && s_tready;

    bomd_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_tdata),
        .end_of_input (s_tlast),
        .batch        (batch)
    );

    bomd_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .batch     (batch),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sym   (out_sym)
    );

    assign m_tdata = {out_sym.offset, out_sym.value};
    assign m_tuser = {out_sym.run_last, out_sym.incomplete, out_sym.enc};
    assign m_tlast = out_sym.stream_done;

endmodule

>>> rtl/bomd_core.sv
module bomd_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              end_of_input,
    output bomd_pkg::batch_t  batch
);

    logic [7:0]          head_reg [3];
    logic [1:0]          head_count_reg;
    logic                det_done_reg;
    bomd_pkg::enc_t      enc_reg;
    logic [31:0]         acc_reg;
    logic [2:0]          col_reg;
    logic [2:0]          exp_reg;
    bomd_pkg::offset_t   pos_reg;
    bomd_pkg::offset_t   start_reg;

    logic [7:0]          lane_b   [4];
    bomd_pkg::offset_t   lane_pos [4];
    logic [3:0]          lane_v;
    bomd_pkg::enc_t      enc_use;
    bomd_pkg::enc_t      det_enc;
    logic [2:0]          det_skip;

    logic [31:0]         acc_next;
    logic [2:0]          col_next;
    logic [2:0]          exp_next;
    bomd_pkg::offset_t   start_next;
    logic [2:0]          cnt;
    bomd_pkg::sym_t [bomd_pkg::MAX_RES-1:0] sym;
    logic                little;
    logic                wide16;
    logic                wide32;

    // Mark check on the three held bytes and the fourth, current byte.
    always_comb
    begin
        det_enc  = bomd_pkg::ENC_UTF8;
        det_skip = 3'd0;
        if (head_reg[0] == bomd_pkg::BYTE_EF && head_reg[1] == bomd_pkg::BYTE_BB
            && head_reg[2] == bomd_pkg::BYTE_BF)
        begin
            det_enc  = bomd_pkg::ENC_UTF8;
            det_skip = 3'd3;
        end
        else if (head_reg[0] == bomd_pkg::BYTE_00 && head_reg[1] == bomd_pkg::BYTE_00
                 && head_reg[2] == bomd_pkg::BYTE_FE && data_byte == bomd_pkg::BYTE_FF)
        begin
            det_enc  = bomd_pkg::ENC_UTF32BE;
            det_skip = 3'd4;
        end
        else if (head_reg[0] == bomd_pkg::BYTE_FF && head_reg[1] == bomd_pkg::BYTE_FE
                 && head_reg[2] == bomd_pkg::BYTE_00 && data_byte == bomd_pkg::BYTE_00)
        begin
            det_enc  = bomd_pkg::ENC_UTF32LE;
            det_skip = 3'd4;
        end
        else if (head_reg[0] == bomd_pkg::BYTE_FE && head_reg[1] == bomd_pkg::BYTE_FF)
        begin
            det_enc  = bomd_pkg::ENC_UTF16BE;
            det_skip = 3'd2;
        end
        else if (head_reg[0] == bomd_pkg::BYTE_FF && head_reg[1] == bomd_pkg::BYTE_FE)
        begin
            det_enc  = bomd_pkg::ENC_UTF16LE;
            det_skip = 3'd2;
        end
    end

    // Choose which bytes are fed this cycle: one byte in the body of the
    // document, or the head buffer when it is flushed.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lane_b[i] = (2'(i) < head_count_reg) ? head_reg[i] : data_byte;
        end
        lane_b[3] = data_byte;
        for (int i = 0; i < 4; i++)
        begin
            lane_pos[i] = bomd_pkg::offset_t'(i);
        end
        lane_v  = 4'b0000;
        enc_use = enc_reg;
        if (det_done_reg)
        begin
            lane_b[0]   = data_byte;
            lane_pos[0] = pos_reg;
            lane_v      = 4'b0001;
        end
        else if (end_of_input)
        begin
            enc_use = bomd_pkg::ENC_UTF8;
            for (int i = 0; i < 4; i++)
            begin
                lane_v[i] = (3'(i) <= {1'b0, head_count_reg});
            end
        end
        else if (head_count_reg == 2'd3)
        begin
            enc_use = det_enc;
            for (int i = 0; i < 4; i++)
            begin
                lane_v[i] = (3'(i) >= det_skip);
            end
        end
    end

    // Up to four symbol-assembly steps in a row, then the final partial flush.
    always_comb
    begin
        little = (enc_use == bomd_pkg::ENC_UTF32LE) || (enc_use == bomd_pkg::ENC_UTF16LE);
        wide16 = (enc_use == bomd_pkg::ENC_UTF16BE) || (enc_use == bomd_pkg::ENC_UTF16LE);
        wide32 = (enc_use == bomd_pkg::ENC_UTF32BE) || (enc_use == bomd_pkg::ENC_UTF32LE);
        acc_next   = acc_reg;
        col_next   = col_reg;
        exp_next   = exp_reg;
        start_next = start_reg;
        cnt        = 3'd0;
        sym        = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (lane_v[i])
            begin
                if (col_next == 3'd0)
                begin
                    start_next = lane_pos[i];
                    acc_next   = 32'd0;
                    if (wide16)
                    begin
                        exp_next = 3'd2;
                    end
                    else if (wide32)
                    begin
                        exp_next = 3'd4;
                    end
                    else
                    begin
                        exp_next = bomd_pkg::utf8_length(lane_b[i]);
                    end
                end
                if (little)
                begin
                    acc_next = acc_next | (32'(lane_b[i]) << {col_next[1:0], 3'b000});
                end
                else
                begin
                    acc_next = {acc_next[23:0], lane_b[i]};
                end
                col_next = col_next + 3'd1;
                if (col_next >= exp_next)
                begin
                    sym[cnt[1:0]].value      = acc_next;
                    sym[cnt[1:0]].offset     = 32'(start_next);
                    sym[cnt[1:0]].enc        = enc_use;
                    sym[cnt[1:0]].incomplete = 1'b0;
                    cnt      = cnt + 3'd1;
                    acc_next = 32'd0;
                    col_next = 3'd0;
                    exp_next = 3'd0;
                end
            end
        end
        if (end_of_input && col_next != 3'd0)
        begin
            sym[cnt[1:0]].value      = acc_next;
            sym[cnt[1:0]].offset     = 32'(start_next);
            sym[cnt[1:0]].enc        = enc_use;
            sym[cnt[1:0]].incomplete = 1'b1;
            cnt = cnt + 3'd1;
        end
        if (cnt != 3'd0)
        begin
            sym[2'(cnt - 3'd1)].run_last    = 1'b1;
            sym[2'(cnt - 3'd1)].stream_done = end_of_input;
        end
    end

    assign batch.count = accept ? cnt : 3'd0;
    assign batch.sym   = sym;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_count_reg <= 2'd0;
            det_done_reg   <= 1'b0;
            enc_reg        <= bomd_pkg::ENC_UTF8;
            acc_reg        <= 32'd0;
            col_reg        <= 3'd0;
            exp_reg        <= 3'd0;
            pos_reg        <= '0;
            start_reg      <= '0;
        end
        else if (accept)
        begin
            if (end_of_input)
            begin
                // The document is over; the next byte starts a new one.
                head_count_reg <= 2'd0;
                det_done_reg   <= 1'b0;
                enc_reg        <= bomd_pkg::ENC_UTF8;
                acc_reg        <= 32'd0;
                col_reg        <= 3'd0;
                exp_reg        <= 3'd0;
                pos_reg        <= '0;
                start_reg      <= '0;
            end
            else
            begin
                acc_reg   <= acc_next;
                col_reg   <= col_next;
                exp_reg   <= exp_next;
                start_reg <= start_next;
                pos_reg   <= pos_reg + bomd_pkg::offset_t'(1);
                if (!det_done_reg)
                begin
                    if (head_count_reg == 2'd3)
                    begin
                        det_done_reg <= 1'b1;
                        enc_reg      <= det_enc;
                    end
                    else
                    begin
                        head_count_reg <= head_count_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !det_done_reg && !end_of_input && head_count_reg != 2'd3)
        begin
            head_reg[head_count_reg] <= data_byte;
        end
    end

endmodule

>>> rtl/bomd_result_fifo.sv
module bomd_result_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  bomd_pkg::batch_t  batch,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output bomd_pkg::sym_t    out_sym
);

    bomd_pkg::sym_t                    mem_reg [bomd_pkg::FIFO_DEPTH];
    logic [bomd_pkg::PTR_BITS-1:0]     wr_ptr_reg;
    logic [bomd_pkg::PTR_BITS-1:0]     rd_ptr_reg;
    logic [bomd_pkg::CNT_BITS-1:0]     count_reg;
    logic                              pop;

    // Room for a whole batch is kept free, so a request is never split.
    assign in_ready  = count_reg <= bomd_pkg::CNT_BITS'(bomd_pkg::FIFO_DEPTH - bomd_pkg::MAX_RES);
    assign out_valid = count_reg != '0;
    assign out_sym   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + bomd_pkg::PTR_BITS'(batch.count);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bomd_pkg::PTR_BITS'(1);
            end
            count_reg <= count_reg + bomd_pkg::CNT_BITS'(batch.count)
                         - bomd_pkg::CNT_BITS'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < bomd_pkg::MAX_RES; i++)
        begin
            if (3'(i) < batch.count)
            begin
                mem_reg[wr_ptr_reg + bomd_pkg::PTR_BITS'(i)] <= batch.sym[i];
            end
        end
    end

endmodule

>>> tb/bom_detect_symbol_reader_tb.sv
`timescale 1ns / 1ps

module bom_detect_symbol_reader_tb;

    localparam int QUIET_LIMIT    = 3000;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_BYTES   = 360;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int MAX_PRINTED    = 40;

    typedef enum int
    {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PATTERN
    } sink_mode_t;

    // Document forms used by the generator; FORM_PLAIN carries no mark.
    typedef enum int
    {
        FORM_UTF8_MARK,
        FORM_UTF32BE,
        FORM_UTF32LE,
        FORM_UTF16BE,
        FORM_UTF16LE,
        FORM_PLAIN
    } doc_form_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] symbol_value, [63:32] symbol_offset
    logic [4:0]  m_tuser;   // [2:0] encoding_kind, [3] incomplete, [4] run_last
    logic        m_tlast;

    // Symbol predictor state.
    logic [7:0]         hd_byte [4];
    int unsigned        hd_fill;
    bit                 enc_known;
    bomd_pkg::enc_t     cur_enc;
    logic [31:0]        sym_acc;
    int unsigned        sym_have;
    int unsigned        sym_need;
    bomd_pkg::offset_t  doc_pos;
    bomd_pkg::offset_t  sym_first;
    bomd_pkg::sym_t     step_syms [bomd_pkg::MAX_RES+1];
    int unsigned        step_n;

    bomd_pkg::sym_t     pending_symbols [$];
    logic [7:0]         doc_bytes [$];

    int          err_count;
    int          bytes_taken;
    int          bytes_sent;
    int          docs_sent;
    int          syms_checked;
    int          partial_seen;
    int          input_stalls;
    int          quiet_cycles;

    sink_mode_t  sink_mode;
    int          sink_hold_req;
    bit          src_gaps_on;
    int          burst_left;

    bom_detect_symbol_reader i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int unsigned utf8_lead_length(input logic [7:0] lead);
        int unsigned ones;
        ones = 0;
        while (ones < 8 && lead[7 - ones])
            ones++;
        if (ones < 2)
            return 1;
        return (ones > 4) ? 4 : ones;
    endfunction

    task automatic clear_predictor();
        hd_fill   = 0;
        enc_known = 1'b0;
        cur_enc   = bomd_pkg::ENC_UTF8;
        sym_acc   = '0;
        sym_have  = 0;
        sym_need  = 0;
        doc_pos   = '0;
        sym_first = '0;
    endtask

    task automatic close_symbol(input bit partial);
        bomd_pkg::sym_t s;
        s.value       = sym_acc;
        s.offset      = sym_first[31:0];
        s.enc         = cur_enc;
        s.incomplete  = partial;
        s.run_last    = 1'b0;
        s.stream_done = 1'b0;
        step_syms[step_n] = s;
        step_n++;
        sym_acc  = '0;
        sym_have = 0;
        sym_need = 0;
    endtask

    task automatic take_byte(input logic [7:0] b, input bomd_pkg::offset_t pos);
        if (sym_have == 0)
        begin
            sym_first = pos;
            sym_acc   = '0;
            case (cur_enc)
                bomd_pkg::ENC_UTF16BE, bomd_pkg::ENC_UTF16LE: sym_need = 2;
                bomd_pkg::ENC_UTF32BE, bomd_pkg::ENC_UTF32LE: sym_need = 4;
                default: sym_need = utf8_lead_length(b);
            endcase
        end
        // Little-endian units fill from the low byte up; the rest shift in.
        if (cur_enc == bomd_pkg::ENC_UTF16LE || cur_enc == bomd_pkg::ENC_UTF32LE)
            sym_acc = sym_acc | (32'(b) << (8 * sym_have));
        else
            sym_acc = {sym_acc[23:0], b};
        sym_have++;
        if (sym_have >= sym_need)
            close_symbol(1'b0);
    endtask

    task automatic predict_symbols(input logic [7:0] b, input logic last);
        logic [31:0]    head;
        int unsigned    skip;
        int unsigned    k;
        bomd_pkg::sym_t s;
        step_n = 0;
        if (!enc_known)
        begin
            hd_byte[hd_fill] = b;
            hd_fill++;
            if (last)
            begin
                cur_enc = bomd_pkg::ENC_UTF8;
                for (k = 0; k < hd_fill; k++)
                    take_byte(hd_byte[k], bomd_pkg::offset_t'(k));
            end
            else if (hd_fill == 4)
            begin
                head = {hd_byte[0], hd_byte[1], hd_byte[2], hd_byte[3]};
                skip = 0;
                cur_enc = bomd_pkg::ENC_UTF8;
                if (head[31:8] == {bomd_pkg::BYTE_EF, bomd_pkg::BYTE_BB, bomd_pkg::BYTE_BF})
                begin
                    skip = 3;
                end
                else if (head == {bomd_pkg::BYTE_00, bomd_pkg::BYTE_00,
                                  bomd_pkg::BYTE_FE, bomd_pkg::BYTE_FF})
                begin
                    skip = 4;
                    cur_enc = bomd_pkg::ENC_UTF32BE;
                end
                else if (head == {bomd_pkg::BYTE_FF, bomd_pkg::BYTE_FE,
                                  bomd_pkg::BYTE_00, bomd_pkg::BYTE_00})
                begin
                    skip = 4;
                    cur_enc = bomd_pkg::ENC_UTF32LE;
                end
                else if (head[31:16] == {bomd_pkg::BYTE_FE, bomd_pkg::BYTE_FF})
                begin
                    skip = 2;
                    cur_enc = bomd_pkg::ENC_UTF16BE;
                end
                else if (head[31:16] == {bomd_pkg::BYTE_FF, bomd_pkg::BYTE_FE})
                begin
                    skip = 2;
                    cur_enc = bomd_pkg::ENC_UTF16LE;
                end
                enc_known = 1'b1;
                for (k = skip; k < 4; k++)
                    take_byte(hd_byte[k], bomd_pkg::offset_t'(k));
            end
        end
        else
        begin
            take_byte(b, doc_pos);
        end
        doc_pos = doc_pos + 1'b1;
        if (last && sym_have != 0)
            close_symbol(1'b1);
        for (k = 0; k < step_n; k++)
        begin
            s = step_syms[k];
            if (k == step_n - 1)
            begin
                s.run_last    = 1'b1;
                s.stream_done = last;
            end
            pending_symbols.push_back(s);
        end
        if (last)
            clear_predictor();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("%0t: %s mismatch at symbol %0d: got %h, expected %h",
                     $time, what, syms_checked, got, want);
    endtask

    // Requests into the block feed the predictor.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_symbols(s_tdata, s_tlast);
            bytes_taken++;
        end
        if (rst_n && s_tvalid && !s_tready)
            input_stalls++;
    end

    always @(posedge clk)
    begin : check_symbols
        bomd_pkg::sym_t got;
        bomd_pkg::sym_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.value       = m_tdata[31:0];
            got.offset      = m_tdata[63:32];
            got.enc         = bomd_pkg::enc_t'(m_tuser[2:0]);
            got.incomplete  = m_tuser[3];
            got.run_last    = m_tuser[4];
            got.stream_done = m_tlast;
            if (pending_symbols.size() == 0)
            begin
                report_mismatch("unexpected symbol", got.value, '0);
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (got.value != want.value)
                    report_mismatch("symbol_value", got.value, want.value);
                if (got.offset != want.offset)
                    report_mismatch("symbol_offset", got.offset, want.offset);
                if (got.enc != want.enc)
                    report_mismatch("encoding_kind", 32'(got.enc), 32'(want.enc));
                if (got.incomplete != want.incomplete)
                    report_mismatch("incomplete", 32'(got.incomplete), 32'(want.incomplete));
                if (got.run_last != want.run_last)
                    report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
                if (got.stream_done != want.stream_done)
                    report_mismatch("stream_done", 32'(got.stream_done),
                                    32'(want.stream_done));
                if (want.incomplete)
                    partial_seen++;
            end
            syms_checked++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no request moved for %0d cycles, %0d symbols outstanding",
                     quiet_cycles, pending_symbols.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: a long hold-off when one is requested, otherwise the current pattern.
    initial
    begin : sink
        int         hold_left;
        int         phase;
        logic [7:0] pat;
        hold_left = 0;
        phase     = 0;
        pat       = 8'hB7;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req != 0)
            begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                case (sink_mode)
                    SINK_ALWAYS: m_tready <= 1'b1;
                    SINK_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        m_tready <= pat[phase];
                        phase = (phase + 1) % 8;
                        if (phase == 0 && $urandom_range(0, 3) == 0)
                            pat = 8'($urandom) | 8'h01;
                    end
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = src_gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_document();
        int i;
        for (i = 0; i < doc_bytes.size(); i++)
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
        docs_sent++;
    endtask

    task automatic test_short_documents();
        sink_mode   = SINK_ALWAYS;
        src_gaps_on = 1'b0;
        doc_bytes = '{8'h00};
        send_document();
        // A full mark that ends the document on its fourth byte is still read as UTF-8.
        doc_bytes = '{8'h00, 8'h00, 8'hFE, 8'hFF};
        send_document();
    endtask

    task automatic test_byte_order_marks();
        sink_mode   = SINK_PATTERN;
        src_gaps_on = 1'b1;
        doc_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h41, 8'hF8};
        send_document();
        doc_bytes = '{8'h00, 8'h00, 8'hFE, 8'hFF, 8'h7F};
        send_document();
        // The four-byte little-endian mark wins over its two-byte prefix.
        doc_bytes = '{8'hFF, 8'hFE, 8'h00, 8'h00, 8'hFF};
        send_document();
        doc_bytes = '{8'hFE, 8'hFF, 8'h12, 8'h34, 8'h56};
        send_document();
        doc_bytes = '{8'hFF, 8'hFE, 8'h34, 8'h12, 8'h80};
        send_document();
        // Four single-byte symbols released together when the head is checked.
        doc_bytes = '{8'h41, 8'h42, 8'h43, 8'h7F, 8'hC3, 8'hA9};
        send_document();
    endtask

    task automatic test_backpressure();
        int d;
        int i;
        sink_mode     = SINK_ALWAYS;
        src_gaps_on   = 1'b0;
        sink_hold_req = HOLD_OFF_LEN;
        for (d = 0; d < 3; d++)
        begin
            doc_bytes.delete();
            for (i = 0; i < 12; i++)
                doc_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            send_document();
        end
    endtask

    task automatic add_utf8_symbol();
        logic [7:0] r;
        int         len;
        int         i;
        r   = 8'($urandom);
        len = $urandom_range(1, 4);
        case (len)
            1: doc_bytes.push_back(($urandom_range(0, 9) == 0) ? {2'b10, r[5:0]}
                                                               : {1'b0, r[6:0]});
            2: doc_bytes.push_back({3'b110, r[4:0]});
            3: doc_bytes.push_back({4'b1110, r[3:0]});
            default: doc_bytes.push_back(($urandom_range(0, 3) == 0) ? {5'b11111, r[2:0]}
                                                                     : {5'b11110, r[2:0]});
        endcase
        for (i = 1; i < len; i++)
            doc_bytes.push_back({2'b10, 6'($urandom)});
    endtask

    task automatic make_random_document();
        doc_form_t form;
        int        kind;
        int        nsym;
        int        cut;
        int        i;
        int        j;
        doc_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 6)
        begin
            form = doc_form_t'($urandom_range(0, 5));
            case (form)
                FORM_UTF8_MARK:
                    doc_bytes = '{bomd_pkg::BYTE_EF, bomd_pkg::BYTE_BB, bomd_pkg::BYTE_BF};
                FORM_UTF32BE:
                    doc_bytes = '{bomd_pkg::BYTE_00, bomd_pkg::BYTE_00,
                                  bomd_pkg::BYTE_FE, bomd_pkg::BYTE_FF};
                FORM_UTF32LE:
                    doc_bytes = '{bomd_pkg::BYTE_FF, bomd_pkg::BYTE_FE,
                                  bomd_pkg::BYTE_00, bomd_pkg::BYTE_00};
                FORM_UTF16BE:
                    doc_bytes = '{bomd_pkg::BYTE_FE, bomd_pkg::BYTE_FF};
                FORM_UTF16LE:
                    doc_bytes = '{bomd_pkg::BYTE_FF, bomd_pkg::BYTE_FE};
                default:
                    doc_bytes.delete();
            endcase
            nsym = $urandom_range(1, 8);
            for (i = 0; i < nsym; i++)
            begin
                case (form)
                    FORM_UTF32BE, FORM_UTF32LE:
                        for (j = 0; j < 4; j++)
                            doc_bytes.push_back(8'($urandom));
                    FORM_UTF16BE, FORM_UTF16LE:
                        for (j = 0; j < 2; j++)
                            doc_bytes.push_back(8'($urandom));
                    default:
                        add_utf8_symbol();
                endcase
            end
            // Now and then the last one to three bytes are dropped, which can stop the document inside its last symbol.
            if ($urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(1, 3);
                while (cut > 0 && doc_bytes.size() > 1)
                begin
                    void'(doc_bytes.pop_back());
                    cut--;
                end
            end
        end
        else
        begin
            nsym = (kind == 7) ? $urandom_range(1, 4) : $urandom_range(1, 12);
            for (i = 0; i < nsym; i++)
                doc_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic test_random_documents();
        while (bytes_sent < RANDOM_BYTES)
        begin
            sink_mode   = sink_mode_t'($urandom_range(0, 2));
            src_gaps_on = ($urandom_range(0, 3) != 0);
            make_random_document();
            send_document();
        end
    endtask

    initial
    begin
        bomd_pkg::sym_t leftover;
        err_count     = 0;
        bytes_taken   = 0;
        bytes_sent    = 0;
        docs_sent     = 0;
        syms_checked  = 0;
        partial_seen  = 0;
        input_stalls  = 0;
        quiet_cycles  = 0;
        sink_mode     = SINK_ALWAYS;
        sink_hold_req = 0;
        src_gaps_on   = 1'b0;
        burst_left    = 0;
        clear_predictor();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_documents();
        test_byte_order_marks();
        test_backpressure();
        test_random_documents();

        s_tvalid <= 1'b0;
        sink_mode = SINK_RANDOM;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        while (pending_symbols.size() != 0)
        begin
            leftover = pending_symbols.pop_front();
            report_mismatch("missing symbol", '0, leftover.value);
        end

        $display("Sent %0d documents (%0d bytes) covering all five marks, short and cut-off"
                 , docs_sent, bytes_taken);
        $display("documents; checked %0d symbols, %0d incomplete, %0d stalled input cycles.",
                 syms_checked, partial_seen, input_stalls);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
